// ===== rtl/core/cksort_pkg.sv =====
`timescale 1ns / 1ps
// Package for the composite key record sorter.
// Holds the field widths, the record type held in each cell and the link between cells.
// No dependencies.
package cksort_pkg;

  localparam int IdW          = 20;
  localparam int ScoreW       = 10;
  localparam int TotalW       = 11;
  localparam int DefMaxRecords = 64;

  // One stored record: identifier, total score and the practical tie-breaker.
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [TotalW-1:0] total;
    logic [ScoreW-1:0] prac;
  } rec_t;

  // What a cell shows to its neighbours.
  typedef struct packed {
    logic valid;
    logic take;
    rec_t rec;
  } link_t;

  // True when record a ranks strictly before record b: higher total, then higher
  // practical score, then lower identifier.
  function automatic logic ranks_before(rec_t a, rec_t b);
    logic [TotalW+ScoreW+IdW-1:0] ka;
    logic [TotalW+ScoreW+IdW-1:0] kb;
    ka = {a.total, a.prac, ~a.id};
    kb = {b.total, b.prac, ~b.id};
    return ka > kb;
  endfunction

endpackage

// ===== rtl/core/cksort_if.sv =====
`timescale 1ns / 1ps
// Handshake interfaces for the record input and the ranked output channels.
// Depends on cksort_pkg for the field widths.
interface cksort_in_if;
  logic                          valid;
  logic                          ready;
  logic [cksort_pkg::IdW-1:0]    record_id;
  logic [cksort_pkg::ScoreW-1:0] theory_score;
  logic [cksort_pkg::ScoreW-1:0] practical_score;
  logic                          last_record;

  modport source (output valid, record_id, theory_score, practical_score, last_record,
                  input ready);
  modport sink (input valid, record_id, theory_score, practical_score, last_record,
                output ready);
endinterface

interface cksort_out_if;
  logic                          valid;
  logic                          ready;
  logic [cksort_pkg::IdW-1:0]    ranked_id;
  logic [cksort_pkg::TotalW-1:0] total_score;
  logic                          final_rank;
  logic                          overflow;

  modport source (output valid, ranked_id, total_score, final_rank, overflow, input ready);
  modport sink (input valid, ranked_id, total_score, final_rank, overflow, output ready);
endinterface

// ===== rtl/core/cksort_cell.sv =====
`timescale 1ns / 1ps
// One cell of the insertion chain: holds a single record in ranked position.
// Depends on cksort_pkg for the record and link types.
module cksort_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              ins,
  input  cksort_pkg::rec_t  new_rec,
  input  logic              shift,
  input  cksort_pkg::link_t left,
  input  cksort_pkg::link_t right,
  output cksort_pkg::link_t self
);

  logic             valid;
  cksort_pkg::rec_t rec;
  logic             take;

  // The new record lands here or further left when it ranks before this one.
  assign take = ins && (!valid || cksort_pkg::ranks_before(new_rec, rec));

  assign self.valid = valid;
  assign self.take  = take;
  assign self.rec   = rec;

  // Control: occupied flag. A taking cell only becomes occupied when it receives the
  // new record or an occupied neighbour's record, never an empty neighbour's contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= right.valid;
    end else if (take && (left.valid || !left.take)) begin
      valid <= 1'b1;
    end
  end

  // Payload: shift towards the head on emission, towards the tail on insertion.
  always_ff @(posedge clk) begin
    if (shift) begin
      rec <= right.rec;
    end else if (take) begin
      if (left.take) begin
        rec <= left.rec;
      end else begin
        rec <= new_rec;
      end
    end
  end

endmodule

// ===== rtl/core/composite_key_record_sorter.sv =====
`timescale 1ns / 1ps
// Composite key record sorter: a chain of insertion cells kept in ranked order.
// Depends on cksort_pkg, cksort_in_if / cksort_out_if and cksort_cell.
//
// Usage:
//   Records arrive on rec_in, one transfer per cycle while loading. Each record is
//   placed in its ranked position in the cell chain in the cycle it is taken, so
//   loading sustains one record per cycle.
//   The transfer that carries last_record ends the set. From the next cycle the
//   chain empties from its head onto rank_out, one result per cycle while the
//   receiver is ready: total descending, practical descending, identifier ascending.
//   rec_in.ready is low during emission. When the receiver stalls, the head cell
//   holds its record and the chain stands still.
//   Records arriving with the chain full are dropped; overflow is then set on every
//   result of that set. final_rank marks the last result, after which the block is
//   empty and loads again.
//   Reset empties every cell and returns the block to loading; no clearing pass.
module composite_key_record_sorter #(
  parameter int MAX_RECORDS = cksort_pkg::DefMaxRecords
) (
  input  logic         clk,
  input  logic         rst,
  cksort_in_if.sink    rec_in,
  cksort_out_if.source rank_out
);

  localparam logic LOAD = 1'b0;
  localparam logic EMIT = 1'b1;

  logic              state;
  logic              state_next;
  logic              dropped;
  logic              dropped_next;
  logic              in_xfer;
  logic              out_xfer;
  logic              full;
  logic              ins;
  logic              shift;
  logic              last_out;
  cksort_pkg::rec_t  new_rec;
  cksort_pkg::link_t links [MAX_RECORDS];
  cksort_pkg::link_t lefts [MAX_RECORDS];
  cksort_pkg::link_t rights[MAX_RECORDS];

  // Build the incoming record with its total score.
  assign new_rec.id    = rec_in.record_id;
  assign new_rec.prac  = rec_in.practical_score;
  assign new_rec.total = {1'b0, rec_in.theory_score} + {1'b0, rec_in.practical_score};

  assign rec_in.ready = (state == LOAD);
  assign in_xfer      = rec_in.valid && rec_in.ready;
  assign full         = links[MAX_RECORDS-1].valid;
  assign ins          = in_xfer && !full;

  // The head cell is the output register.
  assign last_out             = (MAX_RECORDS == 1) ? 1'b1 : !links[1].valid;
  assign rank_out.valid       = (state == EMIT) && links[0].valid;
  assign rank_out.ranked_id   = links[0].rec.id;
  assign rank_out.total_score = links[0].rec.total;
  assign rank_out.final_rank  = last_out;
  assign rank_out.overflow    = dropped;
  assign out_xfer             = rank_out.valid && rank_out.ready;
  assign shift                = out_xfer;

  // Neighbour wiring along the chain.
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_chain
    if (i == 0) begin : g_head
      assign lefts[i] = '0;
    end else begin : g_left
      assign lefts[i] = links[i-1];
    end
    if (i == MAX_RECORDS - 1) begin : g_tail
      assign rights[i] = '0;
    end else begin : g_right
      assign rights[i] = links[i+1];
    end

    cksort_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ins     (ins),
      .new_rec (new_rec),
      .shift   (shift),
      .left    (lefts[i]),
      .right   (rights[i]),
      .self    (links[i])
    );
  end

  // Sequencing between loading and emission, and the dropped-record flag.
  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    unique case (state)
      LOAD: begin
        if (in_xfer && full) begin
          dropped_next = 1'b1;
        end
        if (in_xfer && rec_in.last_record) begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        if (out_xfer && last_out) begin
          state_next   = LOAD;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next = LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= LOAD;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

endmodule

// ===== verif/record_rank_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the composite key record sorter: watches both channels, ranks the loaded
// records itself and compares every ranked output transfer against its own prediction.
// Depends on cksort_pkg and the cksort_in_if / cksort_out_if interfaces.
module record_rank_checker
  import cksort_pkg::*;
#(
  parameter int MAX_RECORDS = DefMaxRecords
) (
  input  logic  clk,
  input  logic  rst,
  cksort_in_if  rec_mon,
  cksort_out_if rank_mon,
  output int    mismatches,
  output int    outstanding
);

  // A record as it was loaded, scores kept apart.
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ScoreW-1:0] theory;
    logic [ScoreW-1:0] practical;
  } loaded_rec_t;

  // One ranked output as the block should present it.
  typedef struct packed {
    logic [IdW-1:0]    ranked_id;
    logic [TotalW-1:0] total;
    logic              final_rank;
    logic              overflow;
  } ranked_rec_t;

  loaded_rec_t set_records[$];
  ranked_rec_t ranked_due[$];
  logic        set_dropped;
  int          errs;

  // True when record a must be emitted ahead of record b.
  function automatic bit outranks(loaded_rec_t a, loaded_rec_t b);
    logic [TotalW-1:0] total_a;
    logic [TotalW-1:0] total_b;
    total_a = TotalW'(a.theory) + TotalW'(a.practical);
    total_b = TotalW'(b.theory) + TotalW'(b.practical);
    if (total_a != total_b) return total_a > total_b;
    if (a.practical != b.practical) return a.practical > b.practical;
    return a.id < b.id;
  endfunction

  // Places a record in ranked position, and on the closing record of a set queues the
  // whole ranking as expected output before emptying the set.
  task automatic load_record(loaded_rec_t rec, logic last);
    int          pos;
    ranked_rec_t out;
    if (set_records.size() < MAX_RECORDS) begin
      pos = set_records.size();
      while (pos > 0 && outranks(rec, set_records[pos-1])) pos--;
      set_records.insert(pos, rec);
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      foreach (set_records[i]) begin
        out.ranked_id  = set_records[i].id;
        out.total      = TotalW'(set_records[i].theory) + TotalW'(set_records[i].practical);
        out.final_rank = (i == set_records.size() - 1);
        out.overflow   = set_dropped;
        ranked_due.push_back(out);
      end
      set_records.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Compares one output transfer with the oldest expected ranking entry.
  task automatic check_ranked();
    ranked_rec_t want;
    if (ranked_due.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("unexpected ranked record: id %0d total %0d final %0b overflow %0b",
                 rank_mon.ranked_id, rank_mon.total_score, rank_mon.final_rank,
                 rank_mon.overflow);
    end else begin
      want = ranked_due.pop_front();
      if (rank_mon.ranked_id !== want.ranked_id || rank_mon.total_score !== want.total ||
          rank_mon.final_rank !== want.final_rank || rank_mon.overflow !== want.overflow) begin
        errs++;
        if (errs <= 10)
          $display("ranked record mismatch: expected id %0d total %0d final %0b overflow %0b, got id %0d total %0d final %0b overflow %0b",
                   want.ranked_id, want.total, want.final_rank, want.overflow,
                   rank_mon.ranked_id, rank_mon.total_score, rank_mon.final_rank,
                   rank_mon.overflow);
      end
    end
  endtask

  // Inputs are taken before outputs so that a same-cycle pair is handled in order.
  always @(posedge clk) begin
    if (rst) begin
      set_records.delete();
      ranked_due.delete();
      set_dropped = 1'b0;
      errs        = 0;
    end else begin
      if (rec_mon.valid && rec_mon.ready)
        load_record('{rec_mon.record_id, rec_mon.theory_score, rec_mon.practical_score},
                    rec_mon.last_record);
      if (rank_mon.valid && rank_mon.ready) check_ranked();
    end
    mismatches  <= errs;
    outstanding <= ranked_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the composite key record sorter: clock, reset, record stimulus,
// receiver back-pressure and the final verdict.
// Depends on cksort_pkg, the channel interfaces, the sorter and record_rank_checker.
module tb_top;
  import cksort_pkg::*;

  localparam int MaxRecords  = DefMaxRecords;
  localparam int RandomItems = 310;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 200000;
  localparam int TailCycles  = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   mismatches;
  int   pending;
  bit   steady_feed = 1'b0;
  int   items_sent = 0;

  cksort_in_if  rec_ch ();
  cksort_out_if rank_ch ();

  composite_key_record_sorter #(
    .MAX_RECORDS(MaxRecords)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .rec_in   (rec_ch),
    .rank_out (rank_ch)
  );

  record_rank_checker #(
    .MAX_RECORDS(MaxRecords)
  ) rank_check (
    .clk         (clk),
    .rst         (rst),
    .rec_mon     (rec_ch),
    .rank_mon    (rank_ch),
    .mismatches  (mismatches),
    .outstanding (pending)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Identifiers: mostly full range, some from a small pool to force identifier ties.
  function automatic logic [IdW-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return IdW'($urandom);
    if (r < 90) return IdW'($urandom_range(0, 7));
    if (r < 95) return '0;
    return '1;
  endfunction

  // Scores: a narrow band makes equal totals and equal practical scores common.
  function automatic logic [ScoreW-1:0] pick_score();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return ScoreW'($urandom_range(0, 1023));
    if (r < 80) return ScoreW'($urandom_range(508, 516));
    if (r < 90) return '0;
    return '1;
  endfunction

  // Offers one record and returns once it has been transferred. Valid is only lowered
  // when a gap follows, so back-to-back records keep it high.
  task automatic send_record(input logic [IdW-1:0] id, input logic [ScoreW-1:0] theory,
                             input logic [ScoreW-1:0] practical, input logic last);
    int gap;
    gap = steady_feed ? 0 : pick_gap();
    if (gap > 0) begin
      rec_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rec_ch.valid           <= 1'b1;
    rec_ch.record_id       <= id;
    rec_ch.theory_score    <= theory;
    rec_ch.practical_score <= practical;
    rec_ch.last_record     <= last;
    do @(posedge clk); while (!rec_ch.ready);
  endtask

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_record(pick_id(), pick_score(), pick_score(), i == n - 1);
    items_sent += n;
  endtask

  // Record stimulus and verdict.
  initial begin : feed
    int set_no;
    int n;
    int r;
    rec_ch.valid           <= 1'b0;
    rec_ch.record_id       <= '0;
    rec_ch.theory_score    <= '0;
    rec_ch.practical_score <= '0;
    rec_ch.last_record     <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Single-record sets at both extremes of every field.
    send_record('1, '1, '1, 1'b1);
    send_record('0, '0, '0, 1'b1);
    // Equal totals split by practical score, then by identifier, plus an exact duplicate.
    send_record(20'd5, 10'd100, 10'd200, 1'b0);
    send_record(20'd3, 10'd200, 10'd100, 1'b0);
    send_record(20'd7, 10'd150, 10'd150, 1'b0);
    send_record(20'd2, 10'd150, 10'd150, 1'b0);
    send_record(20'd2, 10'd150, 10'd150, 1'b0);
    send_record('1, 10'd0, 10'd1023, 1'b0);
    send_record('0, 10'd1023, 10'd0, 1'b0);
    send_record(20'd1, 10'd0, 10'd0, 1'b1);
    // Two records arriving in rising rank order.
    send_record(20'd10, 10'd0, 10'd0, 1'b0);
    send_record(20'd11, 10'd1023, 10'd1023, 1'b1);

    // Random sets, mostly small; at least one exactly full and at least one that overflows,
    // the closing record of an overflowing set being dropped as well.
    set_no = 0;
    while (items_sent < RandomItems) begin
      steady_feed = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (set_no == 2) n = MaxRecords;
      else if (set_no == 5) n = MaxRecords + 2;
      else if (r < 80) n = $urandom_range(1, 10);
      else if (r < 95) n = $urandom_range(11, 30);
      else if (r < 97) n = MaxRecords;
      else n = $urandom_range(MaxRecords + 1, MaxRecords + 3);
      send_set(n);
      set_no++;
    end
    rec_ch.valid <= 1'b0;

    // Drain, then give the block a tail period to show anything spurious.
    do @(posedge clk); while (pending != 0);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random ready pattern with steady stretches, and one long hold-off during an
  // emission so the sorter stays busy while the next set is being offered.
  initial begin : receiver
    bit held_off;
    int gap;
    held_off = 1'b0;
    rank_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held_off && cycles > 300 && rank_ch.valid) begin
        rank_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        held_off = 1'b1;
      end
      rank_ch.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat (80) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        rank_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

endmodule
